@@ sv/shot_event_correlator_macros.svh @@
// ----------------------------------------------------------------------------
// shot event correlator assertion macros
// concurrent checks clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SHOT_EVENT_CORRELATOR_MACROS_SVH
`define SHOT_EVENT_CORRELATOR_MACROS_SVH

`ifndef SYNTH

// antecedent implies consequent in the same cycle
`define SEC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sec check failed");

// antecedent implies consequent in the next cycle
`define SEC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sec check failed");

`else

`define SEC_ASSERT_NOW(lbl, ante, cons)
`define SEC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ sv/sec_pkg.sv @@
// ----------------------------------------------------------------------------
// sec_pkg
// shared types, codes and constants of the shot event correlator
// ----------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

  // input kind codes
  localparam logic [2:0] KIND_TICK   = 3'd0;
  localparam logic [2:0] KIND_SENSOR = 3'd1;
  localparam logic [2:0] KIND_CAMERA = 3'd2;
  localparam logic [2:0] KIND_DRAIN  = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // result kind codes
  localparam logic [1:0] RK_PREVIEW = 2'd0;
  localparam logic [1:0] RK_FINAL   = 2'd1;
  localparam logic [1:0] RK_DRAIN   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_WINDOW   = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [1:0] REG_DRAIN    = 2'd2;

  localparam logic [15:0] WINDOW_RST   = 16'd1500;
  localparam logic [15:0] DEBOUNCE_RST = 16'd200;
  localparam logic [15:0] DRAIN_RST    = 16'd3000;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [23:0] SPLIT_MAX = 24'hFFFFFF;

  // op queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // most results one item can cause
  localparam int MAX_RES = 3;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_SENSOR = 3'd1,
    OP_CAMERA = 3'd2,
    OP_DRAIN  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] score;
    logic [7:0] direction;
  } item_t;

  typedef struct packed {
    logic [1:0]  rk;
    logic [15:0] num;
    logic [7:0]  sc;
    logic [7:0]  dir;
    logic        miss;
    logic        hs;
    logic [23:0] split;
  } res_t;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [15:0] debounce_ms;
    logic [15:0] drain_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

@@ sv/shot_event_correlator.sv @@
// ----------------------------------------------------------------------------
// shot_event_correlator
// pairs sensor triggers with camera detections and reports finalized shots
// ----------------------------------------------------------------------------
// The front takes one input transfer per cycle while the four-entry op queue
// has room; unknown kinds are taken and dropped. The back pops one op per
// cycle while it has no results left to send and loads its results, zero
// to three, into an output slot register that sends one result per
// transfer; the next op is taken in the cycle that the last result
// transfers. Time moves only on tick items. Registers are window_ms at 0x0,
// debounce_ms at 0x4 and drain_wait_ms at 0x8; the user must write them
// only while the block is idle, which the block itself does not enforce.
`default_nettype none

module shot_event_correlator (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [sec_pkg::ADDR_W-1:0] paddr,
  input  wire logic [sec_pkg::DATA_W-1:0] pwdata,
  output logic      [sec_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 kind,
  input  wire logic [7:0]                 score,
  input  wire logic [7:0]                 direction,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      result_kind,
  output logic [15:0]                     shot_number,
  output logic [7:0]                      shot_score,
  output logic [7:0]                      shot_direction,
  output logic                            missed,
  output logic                            has_split,
  output logic [23:0]                     split_ms,
  output logic                            last
);
  import sec_pkg::*;

  `include "shot_event_correlator_macros.svh"

  cfg_t       cfg;
  fifo_stat_t stat;
  item_t      push_item;
  item_t      head_item;
  logic       push;
  logic       pop;
  res_t       res;
  logic       wr_en;
  logic [1:0] reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms     <= WINDOW_RST;
      cfg.debounce_ms   <= DEBOUNCE_RST;
      cfg.drain_wait_ms <= DRAIN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW:   cfg.window_ms     <= pwdata[15:0];
        REG_DEBOUNCE: cfg.debounce_ms   <= pwdata[15:0];
        REG_DRAIN:    cfg.drain_wait_ms <= pwdata[15:0];
        default:      cfg.window_ms     <= cfg.window_ms;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_WINDOW:   prdata = {16'd0, cfg.window_ms};
      REG_DEBOUNCE: prdata = {16'd0, cfg.debounce_ms};
      REG_DRAIN:    prdata = {16'd0, cfg.drain_wait_ms};
      default:      prdata = '0;
    endcase
  end

  sec_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .score     (score),
    .direction (direction),
    .stat      (stat),
    .push      (push),
    .push_item (push_item)
  );

  sec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (head_item),
    .stat      (stat)
  );

  sec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stat      (stat),
    .item      (head_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .res_last  (last)
  );

  // result fields
  assign result_kind    = res.rk;
  assign shot_number    = res.num;
  assign shot_score     = res.sc;
  assign shot_direction = res.dir;
  assign missed         = res.miss;
  assign has_split      = res.hs;
  assign split_ms       = res.split;

  // output checks
  `SEC_ASSERT_NOW(a_drain_blank, out_valid && result_kind == RK_DRAIN, shot_number == 16'd0 && missed == 1'b0 && has_split == 1'b0)
  `SEC_ASSERT_NOW(a_miss_blank, out_valid && missed, result_kind == RK_FINAL && shot_score == 8'd0 && shot_direction == 8'd0)
  `SEC_ASSERT_NOW(a_split_zero, out_valid && !has_split, split_ms == 24'd0)
  `SEC_ASSERT_NEXT(a_more_after, out_valid && !out_ready && !last, out_valid && !last)

endmodule

`default_nettype wire

@@ sv/sec_fifo.sv @@
// ----------------------------------------------------------------------------
// sec_fifo
// short op queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module sec_fifo (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire sec_pkg::item_t     push_item,
  input  wire logic               pop,
  output sec_pkg::item_t          pop_item,
  output sec_pkg::fifo_stat_t     stat
);
  import sec_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  // status flags
  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_item   = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/sec_front.sv @@
// ----------------------------------------------------------------------------
// sec_front
// accepts input items, decodes the kind and queues the op
// ----------------------------------------------------------------------------
`default_nettype none

module sec_front (
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          kind,
  input  wire logic [7:0]          score,
  input  wire logic [7:0]          direction,
  input  wire sec_pkg::fifo_stat_t stat,
  output logic                     push,
  output sec_pkg::item_t           push_item
);
  import sec_pkg::*;

  logic known;
  op_t  op;

  // kind decode, unknown kinds are dropped
  always_comb begin
    known = 1'b1;
    op    = OP_TICK;
    unique case (kind)
      KIND_TICK:   op = OP_TICK;
      KIND_SENSOR: op = OP_SENSOR;
      KIND_CAMERA: op = OP_CAMERA;
      KIND_DRAIN:  op = OP_DRAIN;
      KIND_CLEAR:  op = OP_CLEAR;
      default:     known = 1'b0;
    endcase
  end

  // queue push on each transfer of a known kind
  assign in_ready            = !stat.full;
  assign push                = in_valid && in_ready && known;
  assign push_item.op        = op;
  assign push_item.score     = score;
  assign push_item.direction = direction;

endmodule

`default_nettype wire

@@ sv/sec_back.sv @@
// ----------------------------------------------------------------------------
// sec_back
// correlation state, result generation and output sequencing
// ----------------------------------------------------------------------------
`default_nettype none

module sec_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sec_pkg::cfg_t       cfg,
  input  wire sec_pkg::fifo_stat_t stat,
  input  wire sec_pkg::item_t      item,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sec_pkg::res_t            res,
  output logic                     res_last
);
  import sec_pkg::*;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        pending;
    logic        debouncing;
    logic        draining;
    logic [31:0] pending_time;
    logic [15:0] shot_count;
    logic [31:0] prev_time;
    logic        prev_valid;
    logic [16:0] window_left;
    logic        window_active;
    logic [15:0] debounce_left;
  } st_t;

  st_t         st;
  st_t         st_next;
  res_t        slots      [MAX_RES];
  res_t        slots_next [MAX_RES];
  logic [1:0]  cnt;
  logic [1:0]  nres;

  logic [31:0] diff_base;
  logic [31:0] split_diff;
  logic [23:0] split_val;
  logic [31:0] elapsed;
  logic [16:0] drain_left;
  logic        sensor_go;
  logic        fin_en;
  logic        fin_miss;
  logic        xfer;
  res_t        fin_rec;
  res_t        drain_rec;
  res_t        rec;
  logic [1:0]  k;

  // shared time differences
  assign sensor_go  = (item.op == OP_SENSOR) && !st.debouncing;
  assign diff_base  = (item.op == OP_CAMERA && !st.pending) ? st.now_ms : st.pending_time;
  assign split_diff = diff_base - st.prev_time;
  assign split_val  = !st.prev_valid ? '0 :
                      (|split_diff[31:24]) ? SPLIT_MAX : split_diff[23:0];
  assign elapsed    = st.now_ms - st.pending_time;
  assign drain_left = (elapsed >= {16'd0, cfg.drain_wait_ms}) ? '0 :
                      {1'b0, cfg.drain_wait_ms - elapsed[15:0]};

  // finalize decision per op
  always_comb begin
    fin_en   = 1'b0;
    fin_miss = 1'b1;
    unique case (item.op)
      OP_TICK: begin
        fin_en = st.window_active && (st.window_left <= 17'd1) && st.pending;
      end
      OP_SENSOR: begin
        fin_en = sensor_go && st.pending;
      end
      OP_CAMERA: begin
        fin_en   = st.pending;
        fin_miss = 1'b0;
      end
      default: begin
        fin_en = 1'b0;
      end
    endcase
  end

  // finalized and drain records
  always_comb begin
    fin_rec       = '0;
    fin_rec.rk    = RK_FINAL;
    fin_rec.num   = st.shot_count + 16'd1;
    fin_rec.sc    = fin_miss ? 8'd0 : item.score;
    fin_rec.dir   = fin_miss ? 8'd0 : item.direction;
    fin_rec.miss  = fin_miss;
    fin_rec.hs    = st.prev_valid;
    fin_rec.split = split_val;
    drain_rec     = '0;
    drain_rec.rk  = RK_DRAIN;
  end

  // next state and result list for the op at the queue head
  always_comb begin
    st_next = st;
    for (int i = 0; i < MAX_RES; i++) begin
      slots_next[i] = '0;
    end
    k   = '0;
    rec = '0;

    // timers and debounce arming
    if (item.op == OP_TICK) begin
      st_next.now_ms = st.now_ms + 32'd1;
      if (st.debouncing) begin
        if (st.debounce_left <= 16'd1) begin
          st_next.debouncing    = 1'b0;
          st_next.debounce_left = '0;
        end else begin
          st_next.debounce_left = st.debounce_left - 16'd1;
        end
      end
      if (st.window_active) begin
        if (st.window_left <= 17'd1) begin
          st_next.window_active = 1'b0;
          st_next.window_left   = '0;
        end else begin
          st_next.window_left = st.window_left - 17'd1;
        end
      end
    end
    if (sensor_go) begin
      st_next.debouncing    = 1'b1;
      st_next.debounce_left = cfg.debounce_ms;
    end

    // finalize the pending shot, then the drain it ends
    if (fin_en) begin
      slots_next[k]         = fin_rec;
      k                     = k + 2'd1;
      st_next.shot_count    = st.shot_count + 16'd1;
      st_next.prev_time     = st.pending_time;
      st_next.prev_valid    = 1'b1;
      st_next.pending       = 1'b0;
      st_next.pending_time  = '0;
      st_next.window_active = 1'b0;
      st_next.window_left   = '0;
      if (st.draining) begin
        st_next.draining = 1'b0;
        slots_next[k]    = drain_rec;
        k                = k + 2'd1;
      end
    end

    // op specific actions after finalize
    unique case (item.op)
      OP_SENSOR: begin
        if (sensor_go) begin
          st_next.pending      = 1'b1;
          st_next.pending_time = st.now_ms;
          rec                  = '0;
          rec.rk               = RK_PREVIEW;
          rec.num              = st_next.shot_count + 16'd1;
          slots_next[k]        = rec;
          k                    = k + 2'd1;
          if (cfg.window_ms != '0) begin
            st_next.window_active = 1'b1;
            st_next.window_left   = {1'b0, cfg.window_ms};
          end
        end
      end
      OP_CAMERA: begin
        if (!st.pending) begin
          rec                = '0;
          rec.rk             = RK_FINAL;
          rec.num            = st.shot_count + 16'd1;
          rec.sc             = item.score;
          rec.dir            = item.direction;
          rec.hs             = st.prev_valid;
          rec.split          = split_val;
          slots_next[k]      = rec;
          k                  = k + 2'd1;
          st_next.shot_count = st.shot_count + 16'd1;
          st_next.prev_time  = st.now_ms;
          st_next.prev_valid = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (!st.pending) begin
          slots_next[k] = drain_rec;
          k             = k + 2'd1;
        end else begin
          st_next.draining      = 1'b1;
          st_next.window_left   = drain_left;
          st_next.window_active = 1'b1;
        end
      end
      OP_CLEAR: begin
        st_next        = '0;
        st_next.now_ms = st.now_ms;
      end
      default: begin
        st_next.now_ms = st_next.now_ms;
      end
    endcase
    nres = k;
  end

  // output side, results leave from the head slot
  assign out_valid = (cnt != '0);
  assign res       = slots[0];
  assign res_last  = (cnt == 2'd1);
  assign xfer      = out_valid && out_ready;
  assign pop       = !stat.empty && ((cnt == '0) || (cnt == 2'd1 && out_ready));

  // result slots
  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < MAX_RES; i++) begin
        slots[i] <= slots_next[i];
      end
    end else if (xfer) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  // correlation state and result count
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= '0;
      cnt <= '0;
    end else if (pop) begin
      st  <= st_next;
      cnt <= nres;
    end else if (xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

endmodule

`default_nettype wire
